// ----- hw/rtl/nhpm_pkg.sv -----
// Shared types and constants for the nearest hit pair matcher.
// No dependencies; every other file of the block refers to this package by scoped names.
package nhpm_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   localparam int CUT_BITS  = 17;
   localparam int OUT_BITS  = 17;
   localparam int PROD_BITS = 2 * CUT_BITS;
   localparam int SQ_BITS   = PROD_BITS + 1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CUT_BITS-1:0] CUT_RESET = 17'h10000;

   localparam logic ACTION_PAIR = 1'b0;
   localparam logic ACTION_EOE  = 1'b1;

   localparam logic REG_X_CUT = 1'b0;
   localparam logic REG_Y_CUT = 1'b1;

   localparam logic [1:0] KIND_RESIDUAL = 2'd0;
   localparam logic [1:0] KIND_HIT_A    = 2'd1;
   localparam logic [1:0] KIND_HIT_B    = 2'd2;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_EMIT_A,
      BK_EMIT_B
   } back_state_type;

   // One classified transaction, as handed from the front to the back.
   typedef struct packed {
      logic                       eoe;
      logic                       qual;
      logic [SQ_BITS-1:0]         sq;
      logic signed [OUT_BITS-1:0] dx;
      logic signed [OUT_BITS-1:0] dy;
      logic signed [OUT_BITS-1:0] ax;
      logic signed [OUT_BITS-1:0] ay;
      logic signed [OUT_BITS-1:0] bx;
      logic signed [OUT_BITS-1:0] by;
   } q_entry_type;

endpackage

// ----- hw/rtl/nhpm_req_if.sv -----
// Input channel of the matcher: one hit pair or end of event per transaction.
// Depends on nhpm_pkg for the default coordinate width.
interface nhpm_req_if #(
   parameter int COORD_BITS = nhpm_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;

   modport source (output valid, action, a_x, a_y, b_x, b_y, input ready);
   modport sink   (input valid, action, a_x, a_y, b_x, b_y, output ready);
endinterface

// ----- hw/rtl/nhpm_rsp_if.sv -----
// Result channel of the matcher: residual, hit on A or hit on B per transaction.
// Depends on nhpm_pkg for the output width.
interface nhpm_rsp_if ();
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic signed [nhpm_pkg::OUT_BITS-1:0] out_x;
   logic signed [nhpm_pkg::OUT_BITS-1:0] out_y;
   logic                                 last;

   modport source (output valid, kind, out_x, out_y, last, input ready);
   modport sink   (input valid, kind, out_x, out_y, last, output ready);
endinterface

// ----- hw/rtl/nearest_hit_pair_matcher_unit.sv -----
// Top level of the nearest hit pair matcher: CSR block, front end, queue and back end.
// Depends on nhpm_pkg, nhpm_req_if, nhpm_rsp_if, nhpm_front, nhpm_queue and nhpm_back.
//
// The matcher takes one candidate hit pair (plane A, plane B) per req transaction and
// keeps, per event, the pair with the smallest dx*dx + dy*dy among those with
// |dx| < x_cut and |dy| < y_cut; on a tie the earlier pair stays. An end-of-event
// transaction (action = 1) reports the kept pair as three rsp transactions - the
// residual, then the hit on A, then the hit on B with last set - and clears the event;
// an event with no qualifying pair reports nothing. Candidate pairs are taken at one per
// clock until the queue and both front stages are full: a pair passes a two-stage front
// end (residual and window cut, then squaring) into a QUEUE_DEPTH-entry queue, and the
// back end retires one queued pair per clock with a single compare while not reporting.
// An end of event with a kept pair holds the back end while its three results go out,
// longer while rsp is stalled. Cuts are written over the APB-style CSR port (x_cut at
// 0x0, y_cut at 0x4, 17 bits, reset 65536), by the user only while no transaction is in
// flight, which the block does not enforce; a cut of zero rejects every pair.
module nearest_hit_pair_matcher_unit #(
   parameter int COORD_BITS  = nhpm_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = nhpm_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   nhpm_req_if.sink                           req,
   nhpm_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nhpm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [nhpm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [nhpm_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   localparam int CB = nhpm_pkg::CUT_BITS;

   logic [CB-1:0] x_cut_ff, x_cut_in;
   logic [CB-1:0] y_cut_ff, y_cut_in;
   logic          csr_write;
   logic          csr_index;

   nhpm_pkg::q_entry_type push_data, pop_data;
   logic                  push_valid, push_ready, pop_valid, pop_ready;

   // CSR block: zero wait states, write on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      x_cut_in = x_cut_ff;
      y_cut_in = y_cut_ff;
      if (csr_write) begin
         case (csr_index)
            nhpm_pkg::REG_X_CUT: x_cut_in = csr_pwdata[CB-1:0];
            nhpm_pkg::REG_Y_CUT: y_cut_in = csr_pwdata[CB-1:0];
            default:             x_cut_in = x_cut_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         nhpm_pkg::REG_X_CUT: csr_prdata = nhpm_pkg::CSR_DATA_BITS'(x_cut_ff);
         nhpm_pkg::REG_Y_CUT: csr_prdata = nhpm_pkg::CSR_DATA_BITS'(y_cut_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_cut_ff <= nhpm_pkg::CUT_RESET;
         y_cut_ff <= nhpm_pkg::CUT_RESET;
      end else begin
         x_cut_ff <= x_cut_in;
         y_cut_ff <= y_cut_in;
      end
   end

   // Front end: classify and square each transaction.
   nhpm_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .x_cut      (x_cut_ff),
      .y_cut      (y_cut_ff),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // Queue: decouple the front from the back while results drain.
   nhpm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // Back end: keep the nearest pair, report it at end of event.
   nhpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule

// ----- hw/rtl/nhpm_front.sv -----
// Front end: accepts transactions, forms residuals, applies the window cut, squares.
// Depends on nhpm_pkg and nhpm_req_if.
module nhpm_front #(
   parameter int COORD_BITS = nhpm_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   nhpm_req_if.sink                      req,
   input  logic [nhpm_pkg::CUT_BITS-1:0] x_cut,
   input  logic [nhpm_pkg::CUT_BITS-1:0] y_cut,
   output nhpm_pkg::q_entry_type         push_data,
   output logic                          push_valid,
   input  logic                          push_ready
);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int CMP_BITS  = (DIFF_BITS > nhpm_pkg::CUT_BITS) ? DIFF_BITS : nhpm_pkg::CUT_BITS;
   localparam int CB        = nhpm_pkg::CUT_BITS;
   localparam int OB        = nhpm_pkg::OUT_BITS;
   localparam int PB        = nhpm_pkg::PROD_BITS;
   localparam int SB        = nhpm_pkg::SQ_BITS;

   logic signed [DIFF_BITS-1:0] dx, dy;
   logic [DIFF_BITS-1:0]        mag_x, mag_y;
   logic                        qual;
   logic                        adv1, adv2;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_eoe_ff, s1_qual_ff;
   logic [CB-1:0]       s1_mag_x_ff, s1_mag_y_ff;
   logic signed [OB-1:0] s1_dx_ff, s1_dy_ff, s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;

   logic                s2_valid_ff, s2_valid_in;
   logic                s2_eoe_ff, s2_qual_ff;
   logic [PB-1:0]       s2_sq_x_ff, s2_sq_y_ff;
   logic signed [OB-1:0] s2_dx_ff, s2_dy_ff, s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;

   always_comb begin
      dx    = DIFF_BITS'(req.a_x) - DIFF_BITS'(req.b_x);
      dy    = DIFF_BITS'(req.a_y) - DIFF_BITS'(req.b_y);
      mag_x = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
      mag_y = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
      qual  = (CMP_BITS'(mag_x) < CMP_BITS'(x_cut)) && (CMP_BITS'(mag_y) < CMP_BITS'(y_cut));
   end

   // Advance each stage when the one below has room.
   assign adv2      = !s2_valid_ff || push_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign req.ready = adv1;

   assign s1_valid_in = adv1 ? req.valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_eoe_ff   <= (req.action == nhpm_pkg::ACTION_EOE);
         s1_qual_ff  <= qual;
         s1_mag_x_ff <= CB'(mag_x);
         s1_mag_y_ff <= CB'(mag_y);
         s1_dx_ff    <= OB'(dx);
         s1_dy_ff    <= OB'(dy);
         s1_ax_ff    <= OB'(req.a_x);
         s1_ay_ff    <= OB'(req.a_y);
         s1_bx_ff    <= OB'(req.b_x);
         s1_by_ff    <= OB'(req.b_y);
      end
   end

   // Square the magnitudes; only pairs inside the window use them, so 17 bits suffice.
   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_eoe_ff  <= s1_eoe_ff;
         s2_qual_ff <= s1_qual_ff;
         s2_sq_x_ff <= PB'(s1_mag_x_ff) * PB'(s1_mag_x_ff);
         s2_sq_y_ff <= PB'(s1_mag_y_ff) * PB'(s1_mag_y_ff);
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_bx_ff   <= s1_bx_ff;
         s2_by_ff   <= s1_by_ff;
      end
   end

   assign push_valid = s2_valid_ff;

   always_comb begin
      push_data      = '0;
      push_data.eoe  = s2_eoe_ff;
      push_data.qual = s2_qual_ff;
      push_data.sq   = SB'(s2_sq_x_ff) + SB'(s2_sq_y_ff);
      push_data.dx   = s2_dx_ff;
      push_data.dy   = s2_dy_ff;
      push_data.ax   = s2_ax_ff;
      push_data.ay   = s2_ay_ff;
      push_data.bx   = s2_bx_ff;
      push_data.by   = s2_by_ff;
   end

endmodule

// ----- hw/rtl/nhpm_queue.sv -----
// Short FIFO of classified transactions between the front and the back.
// Depends on nhpm_pkg for the entry type.
module nhpm_queue #(
   parameter int DEPTH = nhpm_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nhpm_pkg::q_entry_type push_data,
   input  logic                  push_valid,
   output logic                  push_ready,
   output nhpm_pkg::q_entry_type pop_data,
   output logic                  pop_valid,
   input  logic                  pop_ready
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   nhpm_pkg::q_entry_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/nhpm_back.sv -----
// Back end: keeps the nearest qualifying pair of the event and reports it at end of event.
// Depends on nhpm_pkg and nhpm_rsp_if.
module nhpm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  nhpm_pkg::q_entry_type pop_data,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   nhpm_rsp_if.source            rsp
);
   localparam int OB = nhpm_pkg::OUT_BITS;
   localparam int SB = nhpm_pkg::SQ_BITS;

   nhpm_pkg::back_state_type state_ff, state_in;

   logic                 found_ff, found_in;
   logic [SB-1:0]        best_sq_ff;
   logic signed [OB-1:0] best_dx_ff, best_dy_ff, best_ax_ff, best_ay_ff, best_bx_ff, best_by_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff;
   logic signed [OB-1:0] rsp_x_ff, rsp_y_ff;
   logic                 rsp_last_ff;

   logic                 out_free, take_pair, update, clear, load_out;
   logic [1:0]           out_kind;
   logic signed [OB-1:0] out_x, out_y;
   logic                 out_last;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   // Strict compare: on a tie keep the earlier pair.
   assign take_pair = pop_data.qual && (!found_ff || (pop_data.sq < best_sq_ff));

   // Outputs of the sequencer.
   always_comb begin
      pop_ready = 1'b0;
      update    = 1'b0;
      clear     = 1'b0;
      load_out  = 1'b0;
      out_kind  = nhpm_pkg::KIND_RESIDUAL;
      out_x     = best_dx_ff;
      out_y     = best_dy_ff;
      out_last  = 1'b0;
      case (state_ff)
         nhpm_pkg::BK_RUN: begin
            if (pop_valid) begin
               if (!pop_data.eoe) begin
                  pop_ready = 1'b1;
                  update    = take_pair;
               end else if (!found_ff) begin
                  pop_ready = 1'b1;
                  clear     = 1'b1;
               end else if (out_free) begin
                  pop_ready = 1'b1;
                  load_out  = 1'b1;
               end
            end
         end
         nhpm_pkg::BK_EMIT_A: begin
            load_out = out_free;
            out_kind = nhpm_pkg::KIND_HIT_A;
            out_x    = best_ax_ff;
            out_y    = best_ay_ff;
         end
         nhpm_pkg::BK_EMIT_B: begin
            load_out = out_free;
            clear    = out_free;
            out_kind = nhpm_pkg::KIND_HIT_B;
            out_x    = best_bx_ff;
            out_y    = best_by_ff;
            out_last = 1'b1;
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nhpm_pkg::BK_RUN: begin
            if (load_out) state_in = nhpm_pkg::BK_EMIT_A;
         end
         nhpm_pkg::BK_EMIT_A: begin
            if (load_out) state_in = nhpm_pkg::BK_EMIT_B;
         end
         nhpm_pkg::BK_EMIT_B: begin
            if (load_out) state_in = nhpm_pkg::BK_RUN;
         end
         default: begin
            state_in = nhpm_pkg::BK_RUN;
         end
      endcase
   end

   assign found_in     = clear ? 1'b0 : (update ? 1'b1 : found_ff);
   assign rsp_valid_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nhpm_pkg::BK_RUN;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         best_sq_ff <= pop_data.sq;
         best_dx_ff <= pop_data.dx;
         best_dy_ff <= pop_data.dy;
         best_ax_ff <= pop_data.ax;
         best_ay_ff <= pop_data.ay;
         best_bx_ff <= pop_data.bx;
         best_by_ff <= pop_data.by;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff <= out_kind;
         rsp_x_ff    <= out_x;
         rsp_y_ff    <= out_y;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind  = rsp_kind_ff;
   assign rsp.out_x = rsp_x_ff;
   assign rsp.out_y = rsp_y_ff;
   assign rsp.last  = rsp_last_ff;

   a_last_on_b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == nhpm_pkg::KIND_HIT_B)))
      else $error("last flag does not match hit-on-B result");

   a_emit_has_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff != nhpm_pkg::BK_RUN) |-> found_ff)
      else $error("emitting results with no pair kept");

   a_eoe_starts_emit: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_data.eoe && found_ff) |=>
         (state_ff == nhpm_pkg::BK_EMIT_A && rsp_valid_ff
          && rsp_kind_ff == nhpm_pkg::KIND_RESIDUAL))
      else $error("end of event did not start the report");

   a_event_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nhpm_pkg::BK_EMIT_B && out_free) |=> (!found_ff && rsp_last_ff))
      else $error("event state not cleared after final result");

endmodule
